/* rtl/core/sqre_pkg.sv */
// Shared types, constants and helper functions for the rotated sprite quad vertex setup.
package sqre_pkg;

  localparam int SINE_TABLE_ENTRIES_DEF = 1024;

  localparam int ANGLE_W    = 13;
  localparam int COL_W      = 8;
  localparam int POS_W      = 16;
  localparam int DIM_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int VIDX_W     = 3;
  localparam int SIN_W      = 15;
  localparam int PROD_W     = DIM_W + SIN_W;
  localparam int SUM_W      = 35;
  localparam int FRAC_SHIFT = 16;
  localparam int SAT_W      = SUM_W - FRAC_SHIFT;
  localparam int REM_W      = 7;

  localparam logic [ANGLE_W-1:0] FULL_TURN_A   = ANGLE_W'(5760);
  localparam logic [ANGLE_W-1:0] QUARTER_A     = ANGLE_W'(1440);
  localparam logic [ANGLE_W-1:0] HALF_A        = ANGLE_W'(2880);
  localparam logic [ANGLE_W-1:0] THREE_QUART_A = ANGLE_W'(4320);
  localparam int QUARTER_TURN = 1440;
  localparam int HALF_QUARTER = 720;

  // divide by 1440 as a shift by 5 and a reciprocal multiply for 45
  localparam int COARSE_SHIFT = 5;
  localparam int FINE_DIV     = 45;
  localparam int RECIP_45     = 372827;
  localparam int RECIP_W      = 19;
  localparam int RECIP_SHIFT  = 24;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // corner signs per vertex TR, TL, BL, BL, BR, TR; bit k is vertex k, 1 means plus
  localparam logic [5:0] CORNER_SX   = 6'b110001;
  localparam logic [5:0] CORNER_SY   = 6'b100011;
  localparam logic [VIDX_W-1:0] FIRST_VERTEX = VIDX_W'(0);
  localparam logic [VIDX_W-1:0] LAST_VERTEX  = VIDX_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
    logic [COL_W-1:0] a;
  } colour_t;

  // Q0.15 sine of a Q30 angle by Taylor series, rounded half up and clamped
  function automatic logic [SIN_W-1:0] table_entry(input longint unsigned x);
    longint unsigned term;
    longint          sum;
    longint          rnd;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0)
        sum = sum - longint'(term);
      else
        sum = sum + longint'(term);
    end
    if (sum < 0)
      sum = 0;
    rnd = (sum + 16384) >>> 15;
    if (rnd > 32767)
      rnd = 32767;
    return rnd[SIN_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] signed_term(input logic [PROD_W-1:0] mag,
                                                          input logic neg);
    logic signed [SUM_W-1:0] ext;
    ext = $signed({{(SUM_W - PROD_W){1'b0}}, mag});
    return neg ? -ext : ext;
  endfunction

  function automatic logic [POS_W-1:0] saturate_pos(input logic [SAT_W-1:0] f);
    logic [POS_W-1:0] res;
    if ((&f[SAT_W-1:POS_W-1]) || !(|f[SAT_W-1:POS_W-1]))
      res = f[POS_W-1:0];
    else if (f[SAT_W-1])
      res = {1'b1, {(POS_W - 1){1'b0}}};
    else
      res = {1'b0, {(POS_W - 1){1'b1}}};
    return res;
  endfunction

endpackage

/* rtl/core/sprite_quad_rotate_expand_top.sv */
// Rotated sprite quad vertex setup: angle and colour in, six saturated vertices out.
//
//   channel   direction  handshake            payload
//   input     in         start / busy         in_angle, in_red, in_green, in_blue, in_alpha
//   result    out        out_strobe           out_vertex_index, out_pos_x/y, out_tex_u/v,
//                                             out_col_r/g/b/a, out_last
//   config    in         cfg_we               cfg_index, cfg_wdata
//
// One item gives six vertices, one per cycle; the sustained rate is set by the vertex
// sequencer that holds the four corner products and loads a new item at the last one.
// The first vertex is registered out once its item has passed every stage; the rest
// follow on consecutive cycles, with no gap before the next item's if stage 5 holds it.
// busy rises only when every stage up to the sequencer holds an item.
// rst_n is synchronous and clears control state and the config registers to zero.
// The receiver cannot stall: every strobed vertex is taken.
module sprite_quad_rotate_expand_top #(
  parameter int SINE_TABLE_ENTRIES = sqre_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sqre_pkg::ANGLE_W-1:0]    in_angle,
  input  logic [sqre_pkg::COL_W-1:0]      in_red,
  input  logic [sqre_pkg::COL_W-1:0]      in_green,
  input  logic [sqre_pkg::COL_W-1:0]      in_blue,
  input  logic [sqre_pkg::COL_W-1:0]      in_alpha,
  output logic                            out_strobe,
  output logic [sqre_pkg::VIDX_W-1:0]     out_vertex_index,
  output logic signed [sqre_pkg::POS_W-1:0] out_pos_x,
  output logic signed [sqre_pkg::POS_W-1:0] out_pos_y,
  output logic                            out_tex_u,
  output logic                            out_tex_v,
  output logic [sqre_pkg::COL_W-1:0]      out_col_r,
  output logic [sqre_pkg::COL_W-1:0]      out_col_g,
  output logic [sqre_pkg::COL_W-1:0]      out_col_b,
  output logic [sqre_pkg::COL_W-1:0]      out_col_a,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [sqre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sqre_pkg::POS_W-1:0]      cfg_wdata
);
  import sqre_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int V_W   = $clog2(QUARTER_TURN * SINE_TABLE_ENTRIES);
  localparam int W_W   = V_W - COARSE_SHIFT;
  localparam int PRD_W = W_W + RECIP_W;

  // ---------------------------------------------------------------- sine ROM
  logic [SIN_W-1:0] sine_rom [SINE_TABLE_ENTRIES + 1];

  for (genvar gi = 0; gi <= SINE_TABLE_ENTRIES; gi++) begin : g_rom
    localparam longint unsigned XQ = (HALF_PI_Q30 * gi) / SINE_TABLE_ENTRIES;
    assign sine_rom[gi] = table_entry(XQ);
  end

  // ---------------------------------------------------------------- config
  logic signed [POS_W-1:0] origin_x_r, origin_y_r;
  logic [DIM_W-1:0]        width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= '0;
      height_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        REG_WIDTH:    width_r    <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en0, en1, en2, en3, en4, en5, en6;
  logic [VIDX_W-1:0] cnt6_r;
  logic accept;

  // a stage may load when empty or when its item moves on
  assign en6    = !v6_r || (cnt6_r == LAST_VERTEX);
  assign en5    = !v5_r || en6;
  assign en4    = !v4_r || en5;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign en0    = !v0_r || en1;
  assign busy   = !en0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      cnt6_r <= FIRST_VERTEX;
    end else begin
      if (en0) v0_r <= accept;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) begin
        v6_r   <= v5_r;
        cnt6_r <= FIRST_VERTEX;
      end else begin
        cnt6_r <= cnt6_r + VIDX_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 0: input
  logic [ANGLE_W-1:0] ang0_r;
  colour_t            col0_r, col1_r, col2_r, col3_r, col4_r, col5_r, col6_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      ang0_r <= in_angle;
      col0_r <= '{r: in_red, g: in_green, b: in_blue, a: in_alpha};
    end
  end

  // ---------------------------------------------------------------- stage 1: quadrant
  logic [ANGLE_W-1:0] ang_wrap, quad_base, rest_full;
  logic [1:0]         quad;
  logic [1:0]         q1_r, q2_r, q3_r, q4_r;
  logic [10:0]        r1_r;

  always_comb begin
    ang_wrap = (ang0_r >= FULL_TURN_A) ? ang0_r - FULL_TURN_A : ang0_r;
    if (ang_wrap >= THREE_QUART_A)
      quad = 2'd3;
    else if (ang_wrap >= HALF_A)
      quad = 2'd2;
    else if (ang_wrap >= QUARTER_A)
      quad = 2'd1;
    else
      quad = 2'd0;
    case (quad)
      2'd1:    quad_base = QUARTER_A;
      2'd2:    quad_base = HALF_A;
      2'd3:    quad_base = THREE_QUART_A;
      default: quad_base = '0;
    endcase
    rest_full = ang_wrap - quad_base;
  end

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      q1_r   <= quad;
      r1_r   <= rest_full[10:0];
      col1_r <= col0_r;
    end
  end

  // ---------------------------------------------------------------- stage 2: scale
  logic [V_W-1:0] vv2_r;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      q2_r   <= q1_r;
      vv2_r  <= V_W'(r1_r) * V_W'(SINE_TABLE_ENTRIES) + V_W'(HALF_QUARTER);
      col2_r <= col1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: reciprocal
  logic [W_W-1:0]   w_coarse, w3_r;
  logic [PRD_W-1:0] recip_prod;
  logic [IDX_W-1:0] q03_r;
  logic             lo3_r;

  assign w_coarse   = vv2_r[V_W-1:COARSE_SHIFT];
  assign recip_prod = PRD_W'(w_coarse) * PRD_W'(RECIP_45);

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      q3_r   <= q2_r;
      w3_r   <= w_coarse;
      q03_r  <= recip_prod[RECIP_SHIFT +: IDX_W];
      lo3_r  <= (vv2_r[COARSE_SHIFT-1:0] == '0);
      col3_r <= col2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: correct
  logic [W_W-1:0]   rem_full;
  logic [REM_W-1:0] rem;
  logic [IDX_W-1:0] idxa4_r;
  logic             exact4_r;

  assign rem_full = w3_r - W_W'(q03_r) * W_W'(FINE_DIV);
  assign rem      = rem_full[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      q4_r     <= q3_r;
      idxa4_r  <= q03_r + IDX_W'(rem >= REM_W'(FINE_DIV));
      exact4_r <= lo3_r && (rem == '0 || rem == REM_W'(FINE_DIV));
      col4_r   <= col3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: table read
  // mirrored index is N + 1 - ceil(v / 1440)
  logic [IDX_W-1:0] idxb, sin_addr, cos_addr;
  logic [SIN_W-1:0] sin5_r, cos5_r;
  logic             sneg5_r, cneg5_r, sneg6_r, cneg6_r;

  assign idxb     = IDX_W'(SINE_TABLE_ENTRIES + 1) - idxa4_r - IDX_W'(!exact4_r);
  assign sin_addr = q4_r[0] ? idxb : idxa4_r;
  assign cos_addr = q4_r[0] ? idxa4_r : idxb;

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      sin5_r  <= sine_rom[sin_addr];
      cos5_r  <= sine_rom[cos_addr];
      sneg5_r <= q4_r[1];
      cneg5_r <= q4_r[1] ^ q4_r[0];
      col5_r  <= col4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6: products
  logic [PROD_W-1:0]       pxc6_r, pxs6_r, pyc6_r, pys6_r;
  logic signed [SUM_W-1:0] bx6_r, by6_r;

  always_ff @(posedge clk) begin
    if (en6 && v5_r) begin
      pxc6_r  <= PROD_W'(width_r) * PROD_W'(cos5_r);
      pxs6_r  <= PROD_W'(width_r) * PROD_W'(sin5_r);
      pyc6_r  <= PROD_W'(height_r) * PROD_W'(cos5_r);
      pys6_r  <= PROD_W'(height_r) * PROD_W'(sin5_r);
      // origin in 16 fraction bits, plus half size, plus the rounding half
      bx6_r   <= $signed({{(SUM_W - 2 * POS_W){origin_x_r[POS_W-1]}}, origin_x_r,
                          {POS_W{1'b0}}})
               + $signed({{(SUM_W - DIM_W - 15){1'b0}}, width_r, 15'd0})
               + $signed(SUM_W'(32768));
      by6_r   <= $signed({{(SUM_W - 2 * POS_W){origin_y_r[POS_W-1]}}, origin_y_r,
                          {POS_W{1'b0}}})
               + $signed({{(SUM_W - DIM_W - 15){1'b0}}, height_r, 15'd0})
               + $signed(SUM_W'(32768));
      sneg6_r <= sneg5_r;
      cneg6_r <= cneg5_r;
      col6_r  <= col5_r;
    end
  end

  // ---------------------------------------------------------------- vertex sequencer
  logic                    sx, sy;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  assign sx = CORNER_SX[cnt6_r];
  assign sy = CORNER_SY[cnt6_r];

  // x = b + cx*cos - cy*sin, y = b + cy*cos + cx*sin with signs folded into each term
  assign sum_x = bx6_r + signed_term(pxc6_r, !sx ^ cneg6_r) + signed_term(pys6_r, sy ^ sneg6_r);
  assign sum_y = by6_r + signed_term(pyc6_r, !sy ^ cneg6_r) + signed_term(pxs6_r, !sx ^ sneg6_r);

  logic out_strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_strobe_r <= 1'b0;
    else
      out_strobe_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (v6_r) begin
      out_vertex_index <= cnt6_r;
      out_pos_x        <= saturate_pos(sum_x[SUM_W-1:FRAC_SHIFT]);
      out_pos_y        <= saturate_pos(sum_y[SUM_W-1:FRAC_SHIFT]);
      out_tex_u        <= sx;
      out_tex_v        <= sy;
      out_col_r        <= col6_r.r;
      out_col_g        <= col6_r.g;
      out_col_b        <= col6_r.b;
      out_col_a        <= col6_r.a;
      out_last         <= (cnt6_r == LAST_VERTEX);
    end
  end

  assign out_strobe = out_strobe_r;

`ifndef SYNTH
  a_vertex_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_vertex_index != LAST_VERTEX
      |=> out_strobe && out_vertex_index == $past(out_vertex_index) + VIDX_W'(1))
    else $error("vertex run broken before its last vertex");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last == (out_vertex_index == LAST_VERTEX)))
    else $error("last flag disagrees with vertex index");

  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> v6_r && v5_r && v0_r && cnt6_r != LAST_VERTEX)
    else $error("busy with room in the pipeline");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !$past(out_strobe) |-> out_vertex_index == FIRST_VERTEX)
    else $error("vertex run did not start at the first vertex");
`endif

endmodule

/* sim/sprite_quad_rotate_expand_top_tb.sv */
// Self-checking testbench for the rotated sprite quad vertex setup block.
module sprite_quad_rotate_expand_top_tb;

  localparam int N_SINE = sqre_pkg::SINE_TABLE_ENTRIES_DEF;
  localparam int TURN   = 5760;
  localparam int QTURN  = 1440;
  // bit k is vertex k in the order TR, TL, BL, BL, BR, TR; 1 means the plus corner
  localparam logic [5:0] RIGHT_SIDE = 6'b110001;
  localparam logic [5:0] TOP_SIDE   = 6'b100011;

  typedef struct packed {
    logic [sqre_pkg::VIDX_W-1:0]       idx;
    logic signed [sqre_pkg::POS_W-1:0] x;
    logic signed [sqre_pkg::POS_W-1:0] y;
    logic                              u;
    logic                              v;
    sqre_pkg::colour_t                 col;
    logic                              last;
  } vertex_t;

  typedef struct {
    logic [sqre_pkg::ANGLE_W-1:0] angle;
    sqre_pkg::colour_t            col;
    int                           gap;
  } sprite_job_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [sqre_pkg::ANGLE_W-1:0]        in_angle = '0;
  logic [sqre_pkg::COL_W-1:0]          in_red = '0;
  logic [sqre_pkg::COL_W-1:0]          in_green = '0;
  logic [sqre_pkg::COL_W-1:0]          in_blue = '0;
  logic [sqre_pkg::COL_W-1:0]          in_alpha = '0;
  logic                                out_strobe;
  logic [sqre_pkg::VIDX_W-1:0]         out_vertex_index;
  logic signed [sqre_pkg::POS_W-1:0]   out_pos_x;
  logic signed [sqre_pkg::POS_W-1:0]   out_pos_y;
  logic                                out_tex_u;
  logic                                out_tex_v;
  logic [sqre_pkg::COL_W-1:0]          out_col_r;
  logic [sqre_pkg::COL_W-1:0]          out_col_g;
  logic [sqre_pkg::COL_W-1:0]          out_col_b;
  logic [sqre_pkg::COL_W-1:0]          out_col_a;
  logic                                out_last;
  logic                                cfg_we = 1'b0;
  logic [sqre_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [sqre_pkg::POS_W-1:0]          cfg_wdata = '0;

  // shadow copy of the sprite registers
  logic signed [sqre_pkg::POS_W-1:0]   org_x = '0;
  logic signed [sqre_pkg::POS_W-1:0]   org_y = '0;
  logic [sqre_pkg::DIM_W-1:0]          size_w = '0;
  logic [sqre_pkg::DIM_W-1:0]          size_h = '0;

  int          quarter_table [0:N_SINE];
  sprite_job_t job_queue[$];
  vertex_t     vertex_queue[$];
  bit          took = 1'b0;
  bit          launched = 1'b0;
  int          gap_left = -1;
  int          err_count = 0;

  sprite_quad_rotate_expand_top #(.SINE_TABLE_ENTRIES(N_SINE)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle(in_angle), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_alpha(in_alpha),
    .out_strobe(out_strobe), .out_vertex_index(out_vertex_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_col_r(out_col_r), .out_col_g(out_col_g), .out_col_b(out_col_b),
    .out_col_a(out_col_a), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Q0.15 sine of quarter-wave step i by an eleven-term Taylor series in Q30
  function automatic int quarter_sine(longint unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    x = (sqre_pkg::HALF_PI_Q30 * i) / N_SINE;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    if (acc < 0)
      acc = 0;
    acc = (acc + 16384) / 32768;
    if (acc > 32767)
      acc = 32767;
    return int'(acc);
  endfunction

  function automatic int sine_at(int p);
    int q;
    int r;
    int idx;
    q = p / QTURN;
    r = p % QTURN;
    if (q % 2 == 1)
      idx = ((QTURN - r) * N_SINE + QTURN / 2) / QTURN;
    else
      idx = (r * N_SINE + QTURN / 2) / QTURN;
    return (q >= 2) ? -quarter_table[idx] : quarter_table[idx];
  endfunction

  // 16 fraction bits down to signed Q16.0, half toward plus infinity, then clamp
  function automatic logic signed [sqre_pkg::POS_W-1:0] to_pos(longint acc20);
    longint f;
    f = (acc20 + 32768) >>> 16;
    if (f > 32767)
      f = 32767;
    if (f < -32768)
      f = -32768;
    return f[sqre_pkg::POS_W-1:0];
  endfunction

  function automatic void predict_quad(logic [sqre_pkg::ANGLE_W-1:0] angle,
                                       sqre_pkg::colour_t col);
    int      a;
    longint  s;
    longint  c;
    longint  hx;
    longint  hy;
    longint  bx;
    longint  by;
    longint  cx;
    longint  cy;
    vertex_t vtx;
    a = int'(angle) % TURN;
    s = sine_at(a);
    c = sine_at((a + QTURN) % TURN);
    hx = size_w;
    hy = size_h;
    bx = longint'(org_x) * 65536 + hx * 32768;
    by = longint'(org_y) * 65536 + hy * 32768;
    for (int k = 0; k < 6; k++) begin
      cx = RIGHT_SIDE[k] ? hx : -hx;
      cy = TOP_SIDE[k] ? hy : -hy;
      vtx.idx  = sqre_pkg::VIDX_W'(k);
      vtx.x    = to_pos(bx + cx * c - cy * s);
      vtx.y    = to_pos(by + cy * c + cx * s);
      vtx.u    = RIGHT_SIDE[k];
      vtx.v    = TOP_SIDE[k];
      vtx.col  = col;
      vtx.last = (k == 5);
      vertex_queue.push_back(vtx);
    end
  endfunction

  // accept transactions, track register writes and check vertices
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    took = rst_n && start && !busy;
    if (!rst_n) begin
      org_x  = '0;
      org_y  = '0;
      size_w = '0;
      size_h = '0;
    end else begin
      if (took)
        predict_quad(in_angle, {in_red, in_green, in_blue, in_alpha});
      if (cfg_we) begin
        case (cfg_index)
          sqre_pkg::REG_ORIGIN_X: org_x = cfg_wdata;
          sqre_pkg::REG_ORIGIN_Y: org_y = cfg_wdata;
          sqre_pkg::REG_WIDTH:    size_w = cfg_wdata[sqre_pkg::DIM_W-1:0];
          sqre_pkg::REG_HEIGHT:   size_h = cfg_wdata[sqre_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        got.idx  = out_vertex_index;
        got.x    = out_pos_x;
        got.y    = out_pos_y;
        got.u    = out_tex_u;
        got.v    = out_tex_v;
        got.col  = {out_col_r, out_col_g, out_col_b, out_col_a};
        got.last = out_last;
        if (vertex_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected vertex idx=%0d x=%0d y=%0d", got.idx, got.x, got.y);
        end else begin
          want = vertex_queue.pop_front();
          if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y ||
              got.u !== want.u || got.v !== want.v || got.col !== want.col ||
              got.last !== want.last) begin
            err_count++;
            if (err_count <= 10) begin
              $display("vertex mismatch: exp idx=%0d x=%0d y=%0d uv=%b%b rgba=%h last=%b",
                       want.idx, want.x, want.y, want.u, want.v, want.col, want.last);
              $display("                 got idx=%0d x=%0d y=%0d uv=%b%b rgba=%h last=%b",
                       got.idx, got.x, got.y, got.u, got.v, got.col, got.last);
            end
          end
        end
      end
    end
  end

  // present queued sprites, each after its own idle gap
  always @(negedge clk) begin
    sprite_job_t job;
    if (launched && took)
      launched = 1'b0;
    if (!launched && job_queue.size() > 0) begin
      if (gap_left < 0)
        gap_left = job_queue[0].gap;
      if (gap_left == 0) begin
        job = job_queue.pop_front();
        in_angle <= job.angle;
        in_red   <= job.col.r;
        in_green <= job.col.g;
        in_blue  <= job.col.b;
        in_alpha <= job.col.a;
        launched = 1'b1;
        gap_left = -1;
      end else begin
        gap_left--;
      end
    end
    start <= launched;
  end

  task automatic add_job(input logic [sqre_pkg::ANGLE_W-1:0] angle,
                         input sqre_pkg::colour_t col, input bit no_gaps);
    sprite_job_t job;
    job.angle = angle;
    job.col   = col;
    job.gap   = no_gaps ? 0 : $urandom_range(0, 9);
    job_queue.push_back(job);
  endtask

  task automatic write_sprite_regs(input logic [15:0] ox, input logic [15:0] oy,
                                   input logic [15:0] w_raw, input logic [15:0] h_raw);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sqre_pkg::REG_ORIGIN_X;
    cfg_wdata <= ox;
    @(negedge clk);
    cfg_index <= sqre_pkg::REG_ORIGIN_Y;
    cfg_wdata <= oy;
    @(negedge clk);
    cfg_index <= sqre_pkg::REG_WIDTH;
    cfg_wdata <= w_raw;
    @(negedge clk);
    cfg_index <= sqre_pkg::REG_HEIGHT;
    cfg_wdata <= h_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every queued sprite is taken and every vertex has come out
  task automatic wait_drained();
    @(negedge clk);
    while (job_queue.size() > 0 || launched || vertex_queue.size() > 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [sqre_pkg::ANGLE_W-1:0] random_angle();
    case ($urandom_range(0, 9))
      0: return sqre_pkg::ANGLE_W'(TURN + $urandom_range(0, 2431));
      1, 2: return sqre_pkg::ANGLE_W'(QTURN * $urandom_range(1, 4) + $urandom_range(0, 4) - 2);
      default: return sqre_pkg::ANGLE_W'($urandom_range(0, TURN - 1));
    endcase
  endfunction

  initial begin
    bit          tight;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] wr;
    logic [15:0] hr;
    for (int i = 0; i <= N_SINE; i++)
      quarter_table[i] = quarter_sine(i);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers still at reset: a degenerate quad on the origin
    add_job(13'd0, 32'h00000000, 1'b0);
    add_job(13'd8191, 32'hFFFFFFFF, 1'b1);
    wait_drained();

    // ordinary sprite through the quadrant boundaries and the wrapping angles
    write_sprite_regs(16'd1600, 16'd800, 16'd512, 16'd256);
    add_job(13'd0, 32'hAA55AA55, 1'b0);
    add_job(13'd1, 32'h55AA55AA, 1'b0);
    add_job(13'd720, 32'h0F0F0F0F, 1'b1);
    add_job(13'd1439, 32'hF0F0F0F0, 1'b1);
    add_job(13'd1440, 32'h12345678, 1'b0);
    add_job(13'd2880, 32'h87654321, 1'b0);
    add_job(13'd4320, 32'hFF00FF00, 1'b1);
    add_job(13'd5759, 32'h00FF00FF, 1'b0);
    add_job(13'd5760, 32'hFFFFFFFF, 1'b0);
    add_job(13'd8191, 32'h00000000, 1'b0);
    wait_drained();

    // largest size at the far corners: positions saturate
    write_sprite_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    add_job(13'd0, 32'hFFFFFFFF, 1'b0);
    add_job(13'd720, 32'h00000000, 1'b1);
    add_job(13'd2160, 32'hAA55AA55, 1'b1);
    add_job(13'd3600, 32'h55AA55AA, 1'b0);
    add_job(13'd5040, 32'h13579BDF, 1'b0);
    wait_drained();

    // top bit of the size writes is dropped
    write_sprite_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000);
    add_job(13'd0, 32'h01020304, 1'b0);
    add_job(13'd1440, 32'hFEFDFCFB, 1'b0);
    add_job(13'd4000, 32'h80808080, 1'b1);
    wait_drained();

    // smallest non-zero size: half steps land on the rounding point
    write_sprite_regs(16'h0000, 16'h0000, 16'h0001, 16'h0001);
    add_job(13'd0, 32'h7F7F7F7F, 1'b0);
    add_job(13'd720, 32'h80808080, 1'b0);
    add_job(13'd2880, 32'h11223344, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 2) == 0) begin
        ox = edge_value();
        oy = edge_value();
        wr = edge_value();
        hr = edge_value();
      end else begin
        ox = 16'($urandom());
        oy = 16'($urandom());
        wr = 16'($urandom());
        hr = 16'($urandom());
      end
      write_sprite_regs(ox, oy, wr, hr);
      tight = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 20; n++)
        add_job(random_angle(), $urandom(), tight);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sprite_quad_rotate_expand_top.f */
rtl/core/sqre_pkg.sv
rtl/core/sprite_quad_rotate_expand_top.sv
sim/sprite_quad_rotate_expand_top_tb.sv
